// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

    // defaults for the top-level parameters
    localparam int FREE_ENTRIES_DEF = 16;
    localparam int ARENA_BITS_DEF   = 32;

    // internal arithmetic width: extents and counters are carried at full width
    localparam int DW = 64;

    localparam int ALIGN_W        = 4;
    localparam int ALIGN_MAX_LOG2 = 12;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_OVER = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic [DW-1:0] start;
        logic [DW-1:0] length;
    } t_ent;

endpackage

// ===== rtl/ffa_mem.sv =====
module ffa_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  ffa_pkg::t_ent       i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output ffa_pkg::t_ent       o_rd_data
);
    import ffa_pkg::*;

    t_ent r_mem [DEPTH];
    t_ent r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// ===== rtl/first_fit_offset_allocator_top.sv =====
// First-fit offset allocator. Each request is an allocate (command 0) or a free
// (command 1); sizes round up to 2^align_log2 bytes (capped at 4 KiB). Free extents
// sit in a sorted table in a single-port-read memory, with a fill count in place of
// per-entry valid bits, so no clearing pass is needed after reset. A request is
// taken only while the sequencer is idle; one result follows per request, held in
// an output register so the next request can be taken while it waits. The time a
// request takes grows with each extent scanned, each entry moved on a removal, and
// each entry visited and each entry moved on an insertion. The extent memory gives
// one read per cycle from a registered port; each step reads an entry, then checks
// it or writes it back.
// align_log2 is written through i_cfg_we/i_cfg_wdata and must only change while idle.
// Byte counters are 64 bits internally; the low 32 bits are reported.
module first_fit_offset_allocator_top #(
    parameter int FREE_ENTRIES = ffa_pkg::FREE_ENTRIES_DEF,
    parameter int ARENA_BITS   = ffa_pkg::ARENA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_command,
    input  logic [31:0]                 i_req_size,
    input  logic [31:0]                 i_free_offset,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [31:0]                 o_block_offset,
    output logic [31:0]                 o_bytes_used,
    output logic [31:0]                 o_arena_peak,
    output logic [ffa_pkg::ST_W-1:0]    o_status,
    input  logic                        i_cfg_we,
    input  logic [ffa_pkg::ALIGN_W-1:0] i_cfg_wdata
);
    import ffa_pkg::*;

    localparam int IW = $clog2(FREE_ENTRIES);
    localparam int CW = $clog2(FREE_ENTRIES + 1);
    localparam logic [DW-1:0] LIM = 64'd1 << ARENA_BITS;
    localparam logic [CW-1:0] N_MAX = CW'(FREE_ENTRIES);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;  // scan: read entry
    localparam logic [3:0] S_SCHK = 4'd3;  // scan: check entry
    localparam logic [3:0] S_POST = 4'd4;  // decide and update
    localparam logic [3:0] S_RMRD = 4'd5;  // remove: read next entry
    localparam logic [3:0] S_RMWR = 4'd6;  // remove: write it one down
    localparam logic [3:0] S_FNRD = 4'd7;  // insert: find position
    localparam logic [3:0] S_FNCK = 4'd8;
    localparam logic [3:0] S_SHRD = 4'd9;  // insert: move entries up
    localparam logic [3:0] S_SHWR = 4'd10;
    localparam logic [3:0] S_INSW = 4'd11; // insert: write new extent
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]          r_state, n_state;
    logic [ALIGN_W-1:0]  r_align;
    logic [CW-1:0]       r_n, n_n;            // extents held (valid prefix)
    logic [DW-1:0]       r_used, n_used;
    logic [DW-1:0]       r_peak, n_peak;

    // per-request working registers
    logic                r_cmd, n_cmd;
    logic [DW-1:0]       r_asize, n_asize;
    logic [DW-1:0]       r_addr, n_addr;
    logic [DW-1:0]       r_off, n_off;
    logic [ST_W-1:0]     r_stat, n_stat;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_after, n_after;    // insert follows the removal
    logic                r_hit, n_hit;
    logic [CW-1:0]       r_hidx, n_hidx;
    t_ent                r_hent, n_hent;      // first-fit entry, or last entry seen
    logic                r_lf, n_lf;
    logic [CW-1:0]       r_lidx, n_lidx;
    t_ent                r_lent, n_lent;
    logic                r_rf, n_rf;
    logic [CW-1:0]       r_ridx, n_ridx;
    logic [DW-1:0]       r_rlen, n_rlen;
    t_ent                r_ins, n_ins;

    // output register
    logic                r_ovalid;
    logic [31:0]         r_o_off, r_o_used, r_o_peak;
    logic [ST_W-1:0]     r_o_stat;
    logic                out_load;

    // memory port
    logic                mem_we, mem_re;
    logic [IW-1:0]       mem_waddr, mem_raddr;
    t_ent                mem_wdata, mem_q;

    // combinational helpers
    logic [ALIGN_MAX_LOG2:0] amask;
    logic [3:0]              a_eff;
    logic [DW-1:0]           end_addr;
    logic [DW-1:0]           q_end;
    logic [CW-1:0]           idx_inc;

    ffa_mem #(
        .DEPTH (FREE_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_q)
    );

    assign o_ready = (r_state == S_IDLE);
    assign a_eff   = (r_align > 4'(ALIGN_MAX_LOG2)) ? 4'(ALIGN_MAX_LOG2) : r_align;
    assign amask   = (13'd1 << a_eff) - 13'd1;
    assign end_addr = r_addr + r_asize;
    assign q_end    = mem_q.start + mem_q.length;
    assign idx_inc  = r_idx + CW'(1);
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_ready);

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_used  = r_used;
        n_peak  = r_peak;
        n_cmd   = r_cmd;
        n_asize = r_asize;
        n_addr  = r_addr;
        n_off   = r_off;
        n_stat  = r_stat;
        n_idx   = r_idx;
        n_k     = r_k;
        n_pos   = r_pos;
        n_after = r_after;
        n_hit   = r_hit;
        n_hidx  = r_hidx;
        n_hent  = r_hent;
        n_lf    = r_lf;
        n_lidx  = r_lidx;
        n_lent  = r_lent;
        n_rf    = r_rf;
        n_ridx  = r_ridx;
        n_rlen  = r_rlen;
        n_ins   = r_ins;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = '0;
        mem_raddr = '0;
        mem_wdata = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_asize = (DW'(i_req_size) + DW'(amask)) & ~DW'(amask);
                    n_addr  = DW'(i_free_offset);
                    n_off   = '0;
                    n_stat  = ST_OK;
                    n_hit   = 1'b0;
                    n_lf    = 1'b0;
                    n_rf    = 1'b0;
                    n_idx   = '0;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_asize == '0) begin
                    if (r_cmd == CMD_ALLOC) begin
                        n_off = r_peak;
                    end
                    n_state = S_DONE;
                end else if (r_cmd == CMD_FREE &&
                             (r_asize > LIM || r_addr > LIM - r_asize)) begin
                    n_stat  = ST_OVER;
                    n_state = S_DONE;
                end else if (r_n == '0) begin
                    n_state = S_POST;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[IW-1:0];
                n_state   = S_SCHK;
            end
            S_SCHK: begin
                n_state = (idx_inc == r_n) ? S_POST : S_SRD;
                n_idx   = idx_inc;
                if (r_cmd == CMD_ALLOC) begin
                    n_hent = mem_q;
                    if (mem_q.length >= r_asize) begin
                        n_hit   = 1'b1;
                        n_hidx  = r_idx;
                        n_state = S_POST;
                    end
                end else begin
                    if (!r_lf && q_end == r_addr) begin
                        n_lf   = 1'b1;
                        n_lidx = r_idx;
                        n_lent = mem_q;
                    end
                    if (!r_rf && mem_q.start == end_addr) begin
                        n_rf   = 1'b1;
                        n_ridx = r_idx;
                        n_rlen = mem_q.length;
                    end
                end
            end
            S_POST: begin
                n_after = 1'b0;
                n_state = S_DONE;
                if (r_cmd == CMD_ALLOC) begin
                    if (r_hit) begin
                        n_off = r_hent.start;
                        if (r_hent.length > r_asize) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_hidx[IW-1:0];
                            mem_wdata.start  = r_hent.start + r_asize;
                            mem_wdata.length = r_hent.length - r_asize;
                        end else begin
                            n_k     = r_hidx;
                            n_state = S_RMRD;
                        end
                    end else if (r_n != '0 &&
                                 r_hent.start + r_hent.length == r_peak) begin
                        // last extent ends at peak: grow it into the block
                        if (r_asize > LIM || r_hent.start > LIM - r_asize) begin
                            n_stat = ST_OVER;
                        end else begin
                            n_off   = r_hent.start;
                            n_peak  = r_hent.start + r_asize;
                            n_k     = r_n - CW'(1);
                            n_state = S_RMRD;
                        end
                    end else if (r_asize > LIM || r_peak > LIM - r_asize) begin
                        n_stat = ST_OVER;
                    end else begin
                        n_off  = r_peak;
                        n_peak = r_peak + r_asize;
                    end
                    if (n_stat == ST_OK) begin
                        if (r_used > (LIM - DW'(1)) - r_asize || r_asize > LIM - DW'(1)) begin
                            n_used = LIM - DW'(1);
                        end else begin
                            n_used = r_used + r_asize;
                        end
                    end
                end else begin
                    n_used = (r_used > r_asize) ? r_used - r_asize : '0;
                    if (r_lf && r_rf && r_lidx != r_ridx) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_lidx[IW-1:0];
                        mem_wdata.start  = r_lent.start;
                        mem_wdata.length = r_lent.length + r_asize + r_rlen;
                        n_k     = r_ridx;
                        n_state = S_RMRD;
                    end else if (r_lf) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_lidx[IW-1:0];
                        mem_wdata.start  = r_lent.start;
                        mem_wdata.length = r_lent.length + r_asize;
                    end else if (r_rf) begin
                        n_ins.start  = r_addr;
                        n_ins.length = r_rlen + r_asize;
                        n_after = 1'b1;
                        n_k     = r_ridx;
                        n_state = S_RMRD;
                    end else if (r_n >= N_MAX) begin
                        n_stat = ST_FULL;
                    end else begin
                        n_ins.start  = r_addr;
                        n_ins.length = r_asize;
                        n_idx = '0;
                        if (r_n == '0) begin
                            n_pos   = '0;
                            n_k     = '0;
                            n_state = S_SHRD;
                        end else begin
                            n_state = S_FNRD;
                        end
                    end
                end
            end
            S_RMRD: begin
                if (r_k + CW'(1) < r_n) begin
                    mem_re    = 1'b1;
                    mem_raddr = IW'(r_k + CW'(1));
                    n_state   = S_RMWR;
                end else begin
                    n_n = r_n - CW'(1);
                    if (!r_after) begin
                        n_state = S_DONE;
                    end else if (r_n == CW'(1)) begin
                        n_pos   = '0;
                        n_k     = '0;
                        n_state = S_SHRD;
                    end else begin
                        n_idx   = '0;
                        n_state = S_FNRD;
                    end
                end
            end
            S_RMWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[IW-1:0];
                mem_wdata = mem_q;
                n_k       = r_k + CW'(1);
                n_state   = S_RMRD;
            end
            S_FNRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[IW-1:0];
                n_state   = S_FNCK;
            end
            S_FNCK: begin
                if (mem_q.start > r_ins.start) begin
                    n_pos   = r_idx;
                    n_k     = r_n;
                    n_state = S_SHRD;
                end else if (idx_inc == r_n) begin
                    n_pos   = r_n;
                    n_k     = r_n;
                    n_state = S_SHRD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_FNRD;
                end
            end
            S_SHRD: begin
                if (r_k > r_pos) begin
                    mem_re    = 1'b1;
                    mem_raddr = IW'(r_k - CW'(1));
                    n_state   = S_SHWR;
                end else begin
                    n_state = S_INSW;
                end
            end
            S_SHWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[IW-1:0];
                mem_wdata = mem_q;
                n_k       = r_k - CW'(1);
                n_state   = S_SHRD;
            end
            S_INSW: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[IW-1:0];
                mem_wdata = r_ins;
                n_n       = r_n + CW'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_align  <= 4'd3;
            r_n      <= '0;
            r_used   <= '0;
            r_peak   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_used  <= n_used;
            r_peak  <= n_peak;
            if (i_cfg_we) begin
                r_align <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working and payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_asize <= n_asize;
        r_addr  <= n_addr;
        r_off   <= n_off;
        r_stat  <= n_stat;
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_pos   <= n_pos;
        r_after <= n_after;
        r_hit   <= n_hit;
        r_hidx  <= n_hidx;
        r_hent  <= n_hent;
        r_lf    <= n_lf;
        r_lidx  <= n_lidx;
        r_lent  <= n_lent;
        r_rf    <= n_rf;
        r_ridx  <= n_ridx;
        r_rlen  <= n_rlen;
        r_ins   <= n_ins;
        if (out_load) begin
            r_o_off  <= r_off[31:0];
            r_o_used <= r_used[31:0];
            r_o_peak <= r_peak[31:0];
            r_o_stat <= r_stat;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_block_offset = r_o_off;
    assign o_bytes_used   = r_o_used;
    assign o_arena_peak   = r_o_peak;
    assign o_status       = r_o_stat;

    // table never holds more extents than it has entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_MAX)
        else $error("extent count beyond table size");

    // writes stay within the valid prefix plus one slot for an insertion
    a_wr_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CW'(mem_waddr) <= r_n))
        else $error("extent write beyond table fill");

    // a result is only produced from the done state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

    // reported status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_FULL || o_status == ST_OVER))
        else $error("undefined status code");

endmodule
